FILE: hdl/csma_tac_pkg.sv
package csma_tac_pkg;

  localparam int HEADER_BYTES    = 4;
  localparam int MAX_FRAME_BYTES = 128;
  localparam int DIV_STEPS       = 16;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_CCA      = 3'd1;
  localparam logic [2:0] PH_BACKOFF  = 3'd2;
  localparam logic [2:0] PH_SENDING  = 3'd3;
  localparam logic [2:0] PH_WAIT_ACK = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_ACK      = 3'd1;
  localparam logic [2:0] ST_COLLISION   = 3'd2;
  localparam logic [2:0] ST_TOO_LONG    = 3'd3;
  localparam logic [2:0] ST_SEND_FAILED = 3'd4;

  localparam logic [2:0] FN_TICK      = 3'd0;
  localparam logic [2:0] FN_ENQUEUE   = 3'd1;
  localparam logic [2:0] FN_SEND_RES  = 3'd2;
  localparam logic [2:0] FN_ACK       = 3'd3;
  localparam logic [2:0] FN_COLLISION = 3'd4;

  localparam logic [1:0] EQ_NONE     = 2'd0;
  localparam logic [1:0] EQ_ACCEPTED = 2'd1;
  localparam logic [1:0] EQ_FULL     = 2'd2;

  localparam logic [2:0] REG_STATION     = 3'd0;
  localparam logic [2:0] REG_MAX_RETRIES = 3'd1;
  localparam logic [2:0] REG_WINDOW_MIN  = 3'd2;
  localparam logic [2:0] REG_WINDOW_MAX  = 3'd3;
  localparam logic [2:0] REG_ACK_TIMEOUT = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic        channel_busy;
    logic [15:0] random_word;
    logic [7:0]  payload_length;
    logic [7:0]  dest_address;
    logic [3:0]  kind_of_frame;
    logic        send_ok;
  } ev_item_t;

  typedef struct packed {
    logic [2:0]  tx_phase;
    logic [1:0]  enqueue_status;
    logic        send_start;
    logic [7:0]  header_type_byte;
    logic [7:0]  header_source;
    logic [7:0]  header_dest;
    logic [7:0]  frame_bytes;
    logic        frame_done;
    logic [2:0]  done_status;
    logic [15:0] backoff_drawn;
    logic [3:0]  queue_count;
  } res_item_t;

  typedef struct packed {
    logic [7:0] len;
    logic [7:0] dest;
    logic [3:0] kind;
    logic [7:0] retries;
  } desc_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_full;
  } dp_stat_t;

endpackage

FILE: hdl/csma_tac_ifs.sv
interface csma_tac_ev_if;
  import csma_tac_pkg::*;
  logic     valid;
  logic     ready;
  ev_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csma_tac_res_if;
  import csma_tac_pkg::*;
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/csma_tac_ctrl.sv
module csma_tac_ctrl
  import csma_tac_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     ev_valid,
  output logic     ev_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] st, st_next;
  logic [3:0] cnt, cnt_next;

  always_comb begin
    cmd      = '0;
    ev_ready = 1'b0;
    st_next  = st;
    cnt_next = cnt;
    unique case (st)
      S_IDLE: begin
        ev_ready = !stat.out_full;
        if (ev_valid && !stat.out_full) begin
          cmd.capture = 1'b1;
          st_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.commit = 1'b1;
        if (stat.need_div) begin
          st_next  = S_DIV;
          cnt_next = '0;
        end else begin
          cmd.finish = 1'b1;
          st_next    = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == 4'(DIV_STEPS - 1)) begin
          cmd.finish = 1'b1;
          st_next    = S_IDLE;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= S_IDLE;
      cnt <= '0;
    end else begin
      st  <= st_next;
      cnt <= cnt_next;
    end
  end

endmodule

FILE: hdl/csma_tac_dp.sv
module csma_tac_dp
  import csma_tac_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
)(
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  ev_item_t  ev_data,
  output res_item_t res_data,
  output logic      res_valid,
  input  logic      res_ready,
  input  logic      cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    wrap_inc = (p == IW'(QUEUE_DEPTH - 1)) ? '0 : p + IW'(1);
  endfunction

  logic [7:0]  station, max_retries;
  logic [15:0] window_min, window_max, ack_timeout;

  logic [2:0]    phase, phase_n;
  logic [IW-1:0] head, head_n, tail, tail_n;
  logic [CW-1:0] count, count_n;
  logic [15:0]   backoff_left, backoff_n, ack_left, ack_n;

  ev_item_t  ev;
  desc_t     desc_q;
  desc_t     ring [QUEUE_DEPTH];
  res_item_t res_n;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  desc_t         wr_data;

  logic [15:0] div_rem, div_dq, div_w, rem_new;
  logic [16:0] trial;

  logic        draw, fail, drop;
  logic [7:0]  draw_r, ret_inc;
  logic [2:0]  fail_st, drop_st;
  logic [8:0]  flen;
  logic [31:0] shifted;
  logic [15:0] window;

  assign ret_inc = (desc_q.retries == 8'hFF) ? 8'hFF : desc_q.retries + 8'd1;
  assign flen    = 9'(HEADER_BYTES) + {1'b0, desc_q.len} + 9'd1;

  always_comb begin
    phase_n   = phase;
    head_n    = head;
    tail_n    = tail;
    count_n   = count;
    backoff_n = backoff_left;
    ack_n     = ack_left;
    res_n     = '0;
    wr_en     = 1'b0;
    wr_addr   = head;
    wr_data   = desc_q;
    draw      = 1'b0;
    draw_r    = desc_q.retries;
    fail      = 1'b0;
    fail_st   = ST_OK;
    drop      = 1'b0;
    drop_st   = ST_OK;
    unique case (ev.func)
      FN_TICK: begin
        unique case (phase)
          PH_IDLE: if (count != '0) phase_n = PH_CCA;
          PH_CCA: begin
            if (count == '0) begin
              phase_n = PH_IDLE;
            end else if (ev.channel_busy) begin
              draw = 1'b1;
            end else if (flen > 9'(MAX_FRAME_BYTES)) begin
              fail    = 1'b1;
              fail_st = ST_TOO_LONG;
            end else begin
              phase_n                = PH_SENDING;
              res_n.send_start       = 1'b1;
              res_n.header_type_byte = {desc_q.kind, 4'd0};
              res_n.header_source    = station;
              res_n.header_dest      = desc_q.dest;
              res_n.frame_bytes      = flen[7:0];
            end
          end
          PH_BACKOFF: begin
            if (backoff_left <= 16'd1) begin
              backoff_n = '0;
              phase_n   = PH_CCA;
            end else begin
              backoff_n = backoff_left - 16'd1;
            end
          end
          PH_WAIT_ACK: begin
            if (ack_left <= 16'd1) begin
              ack_n   = '0;
              fail    = 1'b1;
              fail_st = ST_NO_ACK;
            end else begin
              ack_n = ack_left - 16'd1;
            end
          end
          default: ;
        endcase
      end
      FN_ENQUEUE: begin
        if (count == CW'(QUEUE_DEPTH)) begin
          res_n.enqueue_status = EQ_FULL;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = tail;
          wr_data.len  = ev.payload_length;
          wr_data.dest = ev.dest_address;
          wr_data.kind = ev.kind_of_frame;
          wr_data.retries = '0;
          tail_n       = wrap_inc(tail);
          count_n      = count + CW'(1);
          res_n.enqueue_status = EQ_ACCEPTED;
        end
      end
      FN_SEND_RES: begin
        if (phase == PH_SENDING && count != '0) begin
          if (ev.send_ok) begin
            ack_n   = ack_timeout;
            phase_n = PH_WAIT_ACK;
          end else begin
            fail    = 1'b1;
            fail_st = ST_SEND_FAILED;
          end
        end
      end
      FN_ACK: begin
        if (phase == PH_WAIT_ACK && count != '0) drop = 1'b1;
      end
      FN_COLLISION: begin
        if ((phase == PH_SENDING || phase == PH_WAIT_ACK) && count != '0) begin
          fail    = 1'b1;
          fail_st = ST_COLLISION;
        end
      end
      default: ;
    endcase
    // A failed attempt bumps the head's retry count and the draw sees the new count.
    if (fail) begin
      wr_en           = 1'b1;
      wr_addr         = head;
      wr_data.retries = ret_inc;
      if (ret_inc < max_retries) begin
        draw   = 1'b1;
        draw_r = ret_inc;
      end else begin
        drop    = 1'b1;
        drop_st = fail_st;
      end
    end
    if (drop) begin
      head_n            = wrap_inc(head);
      count_n           = (count != '0) ? count - CW'(1) : count;
      phase_n           = PH_IDLE;
      res_n.frame_done  = 1'b1;
      res_n.done_status = drop_st;
    end
    if (draw) begin
      phase_n   = PH_BACKOFF;
      backoff_n = '0;
    end
    res_n.tx_phase    = phase_n;
    res_n.queue_count = 4'(count_n);
  end

  // Contention window: min(window_min << retries, window_max), zero base gives zero.
  always_comb begin
    shifted = {16'd0, window_min} << draw_r[3:0];
    if (window_min == '0) begin
      window = '0;
    end else if (draw_r >= 8'd16 || shifted > {16'd0, window_max}) begin
      window = window_max;
    end else begin
      window = shifted[15:0];
    end
  end

  assign stat.need_div = draw && (window != '0);
  assign stat.out_full = res_valid;

  assign trial   = {div_rem, div_dq[15]};
  assign rem_new = (trial >= {1'b0, div_w}) ? 16'(trial - {1'b0, div_w}) : trial[15:0];

  always_ff @(posedge clk) begin
    if (wr_en && cmd.commit) ring[wr_addr] <= wr_data;
    if (cmd.capture) desc_q <= ring[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) ev <= ev_data;
    if (cmd.commit) begin
      res_data <= res_n;
      div_w    <= window;
      div_rem  <= '0;
      div_dq   <= ev.random_word;
    end
    if (cmd.div_step) begin
      div_rem <= rem_new;
      div_dq  <= {div_dq[14:0], 1'b0};
      if (cmd.finish) res_data.backoff_drawn <= rem_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station      <= 8'd0;
      max_retries  <= 8'd3;
      window_min   <= 16'd8;
      window_max   <= 16'd1023;
      ack_timeout  <= 16'd100;
      phase        <= PH_IDLE;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      backoff_left <= '0;
      ack_left     <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STATION:     station     <= cfg_data[7:0];
          REG_MAX_RETRIES: max_retries <= cfg_data[7:0];
          REG_WINDOW_MIN:  window_min  <= cfg_data;
          REG_WINDOW_MAX:  window_max  <= cfg_data;
          REG_ACK_TIMEOUT: ack_timeout <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        phase        <= phase_n;
        head         <= head_n;
        tail         <= tail_n;
        count        <= count_n;
        backoff_left <= backoff_n;
        ack_left     <= ack_n;
      end
      if (cmd.div_step && cmd.finish) backoff_left <= rem_new;
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/csma_transmit_access_controller_unit.sv
// Channel    Role    Word        Handshake
// event_ch   sink    ev_item_t   valid/ready
// result_ch  source  res_item_t  valid/ready
// cfg        write   16-bit      cfg_we, no back-pressure
//
// An event is captured into a register and its result word is registered in the execute state;
// an event that draws a nonzero backoff window then runs the bit-serial remainder first.
// One event is in flight; the next is taken once the result register is empty.
// Reset is synchronous; it clears the queue pointers, timers, phase and result valid, and loads the config defaults.
// A stalled result holds its word and blocks new events.
module csma_transmit_access_controller_unit
  import csma_tac_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
)(
  input  logic           clk,
  input  logic           rst,
  csma_tac_ev_if.sink    event_ch,
  csma_tac_res_if.source result_ch,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  csma_tac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (event_ch.valid),
    .ev_ready (event_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csma_tac_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .ev_data   (event_ch.data),
    .res_data  (result_ch.data),
    .res_valid (result_ch.valid),
    .res_ready (result_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: hdl/csma_tac_chk.sv
module csma_tac_chk
  import csma_tac_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      ev_ready,
  input logic      res_valid,
  input logic      res_ready,
  input res_item_t res_data
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !ev_ready)
    else $error("event taken while a result waits");

  a_header_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.send_start |->
      res_data.header_type_byte == 8'd0 && res_data.header_source == 8'd0 &&
      res_data.header_dest == 8'd0 && res_data.frame_bytes == 8'd0)
    else $error("header fields set without a send start");

  a_enq_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.enqueue_status != EQ_NONE |->
      !res_data.send_start && !res_data.frame_done)
    else $error("enqueue result mixed with a transmit result");

endmodule

bind csma_transmit_access_controller_unit csma_tac_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .ev_ready  (event_ch.ready),
  .res_valid (result_ch.valid),
  .res_ready (result_ch.ready),
  .res_data  (result_ch.data)
);

FILE: sim/tb.sv
module tb;
  import csma_tac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 8;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  csma_tac_ev_if ev_ch ();
  csma_tac_res_if res_ch ();

  csma_transmit_access_controller_unit #(.QUEUE_DEPTH(QDEPTH)) u_top (
    .clk(clk), .rst(rst), .event_ch(ev_ch.sink), .result_ch(res_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state.
  logic [7:0] own_addr, retry_limit;
  logic [15:0] cw_min, cw_max, ack_slots;
  logic [2:0] mac_phase;
  desc_t ring [QDEPTH];
  int unsigned head_ix, tail_ix, frames_queued;
  logic [15:0] backoff_cnt, ack_cnt;

  res_item_t expected_q[$];
  int errors = 0;
  int words_in = 0, words_out = 0, frames_sent = 0, frames_dropped = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit sink_pause = 0;

  task automatic model_reset();
    own_addr = 8'd0; retry_limit = 8'd3; cw_min = 16'd8; cw_max = 16'd1023;
    ack_slots = 16'd100; mac_phase = PH_IDLE;
    head_ix = 0; tail_ix = 0; frames_queued = 0; backoff_cnt = 0; ack_cnt = 0;
    for (int i = 0; i < QDEPTH; i++) ring[i] = '0;
  endtask

  function automatic void draw_slots(input logic [15:0] rnd, inout res_item_t r);
    longint unsigned w;
    int unsigned tries;
    tries = ring[head_ix].retries;
    if (cw_min == 0) w = 0;
    else if (tries >= 32) w = cw_max;
    else begin
      w = longint'(cw_min) << tries;
      if (w > cw_max) w = cw_max;
    end
    backoff_cnt = (w == 0) ? 16'd0 : 16'(rnd % w);
    mac_phase = PH_BACKOFF;
    r.backoff_drawn = backoff_cnt;
  endfunction

  function automatic void drop_frame(input logic [2:0] status, inout res_item_t r);
    head_ix = (head_ix + 1) % QDEPTH;
    if (frames_queued > 0) frames_queued--;
    mac_phase = PH_IDLE;
    r.frame_done = 1'b1;
    r.done_status = status;
  endfunction

  function automatic void fail_attempt(input logic [2:0] status, input logic [15:0] rnd,
                                       inout res_item_t r);
    if (ring[head_ix].retries != 8'hFF) ring[head_ix].retries++;
    if (ring[head_ix].retries < retry_limit) draw_slots(rnd, r);
    else drop_frame(status, r);
  endfunction

  function automatic res_item_t predict_access(input ev_item_t e);
    res_item_t r;
    int unsigned flen;
    r = '0;
    case (e.func)
      FN_TICK: begin
        case (mac_phase)
          PH_IDLE: if (frames_queued > 0) mac_phase = PH_CCA;
          PH_CCA: begin
            if (frames_queued == 0) mac_phase = PH_IDLE;
            else if (e.channel_busy) draw_slots(e.random_word, r);
            else begin
              flen = HEADER_BYTES + ring[head_ix].len + 1;
              if (flen > MAX_FRAME_BYTES) fail_attempt(ST_TOO_LONG, e.random_word, r);
              else begin
                mac_phase = PH_SENDING;
                r.send_start = 1'b1;
                r.header_type_byte = {ring[head_ix].kind, 4'd0};
                r.header_source = own_addr;
                r.header_dest = ring[head_ix].dest;
                r.frame_bytes = 8'(flen);
              end
            end
          end
          PH_BACKOFF: begin
            if (backoff_cnt <= 1) begin
              backoff_cnt = 0; mac_phase = PH_CCA;
            end else backoff_cnt--;
          end
          PH_WAIT_ACK: begin
            if (ack_cnt <= 1) begin
              ack_cnt = 0; fail_attempt(ST_NO_ACK, e.random_word, r);
            end else ack_cnt--;
          end
          default: ;
        endcase
      end
      FN_ENQUEUE: begin
        if (frames_queued >= QDEPTH) r.enqueue_status = EQ_FULL;
        else begin
          ring[tail_ix] = {e.payload_length, e.dest_address, e.kind_of_frame, 8'd0};
          tail_ix = (tail_ix + 1) % QDEPTH;
          frames_queued++;
          r.enqueue_status = EQ_ACCEPTED;
        end
      end
      FN_SEND_RES: begin
        if (mac_phase == PH_SENDING && frames_queued > 0) begin
          if (e.send_ok) begin
            ack_cnt = ack_slots; mac_phase = PH_WAIT_ACK;
          end else fail_attempt(ST_SEND_FAILED, e.random_word, r);
        end
      end
      FN_ACK: if (mac_phase == PH_WAIT_ACK && frames_queued > 0) drop_frame(ST_OK, r);
      FN_COLLISION: begin
        if ((mac_phase == PH_SENDING || mac_phase == PH_WAIT_ACK) && frames_queued > 0)
          fail_attempt(ST_COLLISION, e.random_word, r);
      end
      default: ;
    endcase
    r.tx_phase = mac_phase;
    r.queue_count = 4'(frames_queued);
    return r;
  endfunction

  // Sink side: random stalls plus a long hold-off when requested.
  int sink_gap = 0;
  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else if (hold_off) res_ch.ready <= 1'b0;
    else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      res_ch.ready <= 1'b0;
    end else if (!sink_pause && $urandom_range(0, 3) == 0) begin
      sink_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      res_ch.ready <= 1'b0;
    end else res_ch.ready <= 1'b1;
  end

  task automatic check_word(input res_item_t got);
    res_item_t want;
    if (expected_q.size() == 0) begin
      $error("result word with nothing expected: %h", got);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.tx_phase !== want.tx_phase) begin
      $error("tx_phase exp %0d got %0d", want.tx_phase, got.tx_phase); errors++;
    end
    if (got.enqueue_status !== want.enqueue_status) begin
      $error("enqueue_status exp %0d got %0d", want.enqueue_status, got.enqueue_status);
      errors++;
    end
    if (got.send_start !== want.send_start) begin
      $error("send_start exp %0d got %0d", want.send_start, got.send_start); errors++;
    end
    if (got.header_type_byte !== want.header_type_byte) begin
      $error("header_type_byte exp %0h got %0h", want.header_type_byte,
             got.header_type_byte); errors++;
    end
    if (got.header_source !== want.header_source) begin
      $error("header_source exp %0h got %0h", want.header_source, got.header_source);
      errors++;
    end
    if (got.header_dest !== want.header_dest) begin
      $error("header_dest exp %0h got %0h", want.header_dest, got.header_dest); errors++;
    end
    if (got.frame_bytes !== want.frame_bytes) begin
      $error("frame_bytes exp %0d got %0d", want.frame_bytes, got.frame_bytes); errors++;
    end
    if (got.frame_done !== want.frame_done) begin
      $error("frame_done exp %0d got %0d", want.frame_done, got.frame_done); errors++;
    end
    if (got.done_status !== want.done_status) begin
      $error("done_status exp %0d got %0d", want.done_status, got.done_status); errors++;
    end
    if (got.backoff_drawn !== want.backoff_drawn) begin
      $error("backoff_drawn exp %0d got %0d", want.backoff_drawn, got.backoff_drawn);
      errors++;
    end
    if (got.queue_count !== want.queue_count) begin
      $error("queue_count exp %0d got %0d", want.queue_count, got.queue_count); errors++;
    end
    if (want.send_start) frames_sent++;
    if (want.frame_done) frames_dropped++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        check_word(res_ch.data);
        words_out++;
      end
      if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Valid stays high into the next word when there is no gap.
  task automatic send_word(input ev_item_t e);
    int gap;
    gap = ($urandom_range(0, 3) != 0) ? 0 :
          (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3));
    if (gap != 0) begin
      ev_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_ch.valid <= 1'b1;
    ev_ch.data <= e;
    @(posedge clk);
    while (!ev_ch.ready) @(posedge clk);
    expected_q.push_back(predict_access(e));
    words_in++;
  endtask

  task automatic drain();
    ev_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_STATION:     own_addr = val[7:0];
      REG_MAX_RETRIES: retry_limit = val[7:0];
      REG_WINDOW_MIN:  cw_min = val;
      REG_WINDOW_MAX:  cw_max = val;
      REG_ACK_TIMEOUT: ack_slots = val;
      default: ;
    endcase
  endtask

  function automatic ev_item_t mk(input logic [2:0] f, input logic busy,
                                  input logic [15:0] rnd, input logic [7:0] len,
                                  input logic [7:0] dst, input logic [3:0] kind,
                                  input logic ok);
    ev_item_t e;
    e = {f, busy, rnd, len, dst, kind, ok};
    return e;
  endfunction

  function automatic ev_item_t rand_word(input bit mostly_good);
    ev_item_t e;
    int pick;
    e = ev_item_t'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    // Ticks dominate so the phase machine and timers move; other events
    // mostly come in phase, the rest is noise.
    if (pick < 55) e.func = FN_TICK;
    else if (pick < 70) e.func = FN_ENQUEUE;
    else if (pick < 82) e.func = FN_SEND_RES;
    else if (pick < 90) e.func = FN_ACK;
    else if (pick < 96) e.func = FN_COLLISION;
    else e.func = 3'($urandom_range(5, 7));
    if (mostly_good) begin
      if (mac_phase == PH_SENDING && $urandom_range(0, 1)) e.func = FN_SEND_RES;
      if (mac_phase == PH_WAIT_ACK && $urandom_range(0, 2) == 0) e.func = FN_ACK;
      if (e.func == FN_SEND_RES) e.send_ok = ($urandom_range(0, 3) != 0);
      if (e.func == FN_ENQUEUE && $urandom_range(0, 4) != 0)
        e.payload_length = 8'($urandom_range(0, 130));
      e.channel_busy = ($urandom_range(0, 3) == 0);
    end
    return e;
  endfunction

  typedef struct {
    ev_item_t ev;
    bit has_exp;
    res_item_t exp_res;
  } dir_row_t;

  dir_row_t dir_rows[$];
  res_item_t got_exp;

  initial begin
    ev_ch.valid = 1'b0;
    ev_ch.data = '0;
    model_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; a few have their answer written out.
    dir_rows.push_back('{mk(FN_TICK, 1, 16'hFFFF, 0, 0, 0, 0), 1,
                         '{tx_phase: PH_IDLE, default: '0}});
    dir_rows.push_back('{mk(FN_ACK, 0, 0, 0, 0, 0, 1), 1,
                         '{tx_phase: PH_IDLE, default: '0}});
    dir_rows.push_back('{mk(3'd7, 1, 16'hFFFF, 8'hFF, 8'hFF, 4'hF, 1), 1,
                         '{tx_phase: PH_IDLE, default: '0}});
    dir_rows.push_back('{mk(FN_ENQUEUE, 0, 0, 8'd0, 8'hFF, 4'hF, 0), 1,
                         '{tx_phase: PH_IDLE, enqueue_status: EQ_ACCEPTED,
                           queue_count: 4'd1, default: '0}});
    dir_rows.push_back('{mk(FN_ENQUEUE, 0, 0, 8'hFF, 8'h00, 4'h0, 0), 0, '0});
    dir_rows.push_back('{mk(FN_ENQUEUE, 0, 0, 8'd123, 8'h5A, 4'hA, 0), 0, '0});
    dir_rows.push_back('{mk(FN_TICK, 0, 0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(FN_TICK, 1, 16'hFFFF, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(FN_TICK, 0, 0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(FN_TICK, 0, 0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(FN_TICK, 0, 0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(FN_SEND_RES, 0, 0, 0, 0, 0, 1), 0, '0});
    dir_rows.push_back('{mk(FN_ACK, 0, 0, 0, 0, 0, 0), 0, '0});
    // Ticks run the backoff down and then issue the head frame.
    for (int i = 0; i < 12; i++)
      dir_rows.push_back('{mk(FN_TICK, i[0], 16'h1234, 0, 0, 0, 0), 0, '0});
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].ev);
      if (dir_rows[i].has_exp) begin
        got_exp = expected_q[$];
        if (got_exp !== dir_rows[i].exp_res) begin
          $error("directed row %0d: typed answer %h, predictor %h", i,
                 dir_rows[i].exp_res, got_exp);
          errors++;
        end
      end
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_STATION, 16'h00A5); write_reg(REG_MAX_RETRIES, 16'd4);
          write_reg(REG_WINDOW_MIN, 16'd2); write_reg(REG_WINDOW_MAX, 16'd20);
          write_reg(REG_ACK_TIMEOUT, 16'd3);
        end
        1: begin
          write_reg(REG_STATION, 16'h00FF); write_reg(REG_MAX_RETRIES, 16'd0);
          write_reg(REG_WINDOW_MIN, 16'd0); write_reg(REG_ACK_TIMEOUT, 16'd0);
        end
        2: begin
          write_reg(REG_STATION, 16'h0000); write_reg(REG_MAX_RETRIES, 16'd255);
          write_reg(REG_WINDOW_MIN, 16'hFFFF); write_reg(REG_WINDOW_MAX, 16'hFFFF);
          write_reg(REG_ACK_TIMEOUT, 16'd1);
        end
        3: begin
          write_reg(REG_MAX_RETRIES, 16'd40); write_reg(REG_WINDOW_MIN, 16'd1);
          write_reg(REG_WINDOW_MAX, 16'd0); write_reg(REG_ACK_TIMEOUT, 16'd2);
        end
        4: begin
          write_reg(REG_MAX_RETRIES, 16'd6); write_reg(REG_WINDOW_MIN, 16'd3);
          write_reg(REG_WINDOW_MAX, 16'd40); write_reg(REG_ACK_TIMEOUT, 16'hFFFF);
        end
        default: begin
          write_reg(REG_STATION, 16'h3C); write_reg(REG_MAX_RETRIES, 16'd2);
          write_reg(REG_WINDOW_MIN, 16'd4); write_reg(REG_WINDOW_MAX, 16'd16);
          write_reg(REG_ACK_TIMEOUT, 16'd4);
        end
      endcase
      cfg_we <= 1'b0;
      if (ph == 2) begin
        // Hold the result side off while words keep coming so the block stalls.
        fork
          begin
            hold_off = 1;
            repeat (60) @(posedge clk);
            hold_off = 0;
          end
          for (int i = 0; i < 10; i++) send_word(rand_word(1));
        join
      end
      if (ph == 4) sink_pause = 1;
      for (int i = 0; i < 185; i++) send_word(rand_word($urandom_range(0, 4) != 0));
      sink_pause = 0;
      drain();
    end

    $display("Checked %0d event words and %0d result words over six register settings.",
             words_in, words_out);
    $display("Headers issued: %0d, frames completed or dropped: %0d.",
             frames_sent, frames_dropped);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
